[sv/step_function_lookup_top_assert.svh]
// ---------------------------------------------------------------------------
// Step function lookup assertion macros
// Concurrent assertion forms for the lookup controller.
// ---------------------------------------------------------------------------
`ifndef STEP_FUNCTION_LOOKUP_TOP_ASSERT_SVH
`define STEP_FUNCTION_LOOKUP_TOP_ASSERT_SVH

// same-cycle implication
`define SFL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfl assertion failed");

// next-cycle implication
`define SFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfl assertion failed");

`endif

[sv/sfl_pkg.sv]
// ---------------------------------------------------------------------------
// Step function lookup package
// Widths, register map, controller states and command/status types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfl_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = IDX_W + 1;
    localparam int LOAD_W        = 10;
    localparam int ENTRY_COUNT_W = 11;
    localparam int KEY_W         = 32;
    localparam int VAL_W         = 32;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SEARCH,
        ST_FINISH,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic load;
        logic init;
        logic first;
        logic step;
        logic fetch;
    } cmd_t;

    typedef struct packed {
        logic open;
    } status_t;

endpackage

[sv/sfl_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with enable and registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/sfl_ctrl.sv]
// ---------------------------------------------------------------------------
// Step function lookup controller
// Sequences load writes and the bisection steps of one query.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "step_function_lookup_top_assert.svh"

module sfl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             req_type,
    input  sfl_pkg::status_t status,
    output sfl_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);

    sfl_pkg::state_t state_reg;
    sfl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            sfl_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (req_type == sfl_pkg::REQ_QUERY)
                    begin
                        cmd.init   = 1'b1;
                        state_next = sfl_pkg::ST_SETUP;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            sfl_pkg::ST_SETUP:
            begin
                cmd.first  = 1'b1;
                state_next = status.open ? sfl_pkg::ST_SEARCH : sfl_pkg::ST_FINISH;
            end
            sfl_pkg::ST_SEARCH:
            begin
                cmd.step   = 1'b1;
                state_next = status.open ? sfl_pkg::ST_SEARCH : sfl_pkg::ST_FINISH;
            end
            sfl_pkg::ST_FINISH:
            begin
                cmd.fetch  = 1'b1;
                state_next = sfl_pkg::ST_REPORT;
            end
            sfl_pkg::ST_REPORT:
            begin
                done       = 1'b1;
                state_next = sfl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sfl_pkg::ST_IDLE;
            end
        endcase
    end

    `SFL_ASSERT_NEXT(a_query_goes_busy, clk, rst_n,
        start && !busy && (req_type == sfl_pkg::REQ_QUERY), busy)
    `SFL_ASSERT_NEXT(a_load_stays_free, clk, rst_n,
        start && !busy && (req_type == sfl_pkg::REQ_LOAD), !busy)
    `SFL_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done && !busy)
    `SFL_ASSERT_NEXT(a_fetch_then_done, clk, rst_n, cmd.fetch, done)

endmodule

[sv/sfl_datapath.sv]
// ---------------------------------------------------------------------------
// Step function lookup datapath
// Key and value stores, bisection bounds and result selection.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfl_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  sfl_pkg::cmd_t                           cmd,
    output sfl_pkg::status_t                        status,
    input  logic [sfl_pkg::ENTRY_COUNT_W-1:0]       entry_count,
    input  logic [sfl_pkg::LOAD_W-1:0]              load_index,
    input  logic signed [sfl_pkg::KEY_W-1:0]        key,
    input  logic [sfl_pkg::VAL_W-1:0]               entry_value,
    output logic                                    found,
    output logic [sfl_pkg::LOAD_W-1:0]              found_index,
    output logic [sfl_pkg::VAL_W-1:0]               step_value
);

    logic [sfl_pkg::CNT_W-1:0]        lo_reg;
    logic [sfl_pkg::CNT_W-1:0]        lo_next;
    logic [sfl_pkg::CNT_W-1:0]        hi_reg;
    logic [sfl_pkg::CNT_W-1:0]        hi_next;
    logic [sfl_pkg::IDX_W-1:0]        mid_reg;
    logic [sfl_pkg::IDX_W-1:0]        mid_next;
    logic signed [sfl_pkg::KEY_W-1:0] query_reg;
    logic [sfl_pkg::CNT_W-1:0]        limit;
    logic [sfl_pkg::CNT_W-1:0]        step_lo;
    logic [sfl_pkg::CNT_W-1:0]        step_hi;
    logic [sfl_pkg::CNT_W-1:0]        src_lo;
    logic [sfl_pkg::CNT_W-1:0]        src_hi;
    logic [sfl_pkg::CNT_W:0]          mid_sum;
    logic [sfl_pkg::CNT_W-1:0]        last_idx;
    logic [sfl_pkg::KEY_W-1:0]        key_rdata;
    logic [sfl_pkg::VAL_W-1:0]        val_rdata;
    logic                             key_below;
    logic                             load_we;
    logic [sfl_pkg::IDX_W-1:0]        load_addr;

    assign limit = (32'(entry_count) > 32'(sfl_pkg::TABLE_DEPTH))
                 ? sfl_pkg::CNT_W'(sfl_pkg::TABLE_DEPTH)
                 : sfl_pkg::CNT_W'(entry_count);

    assign load_we   = cmd.load && (32'(load_index) < 32'(sfl_pkg::TABLE_DEPTH));
    assign load_addr = sfl_pkg::IDX_W'(load_index);

    assign key_below = $signed(key_rdata) < query_reg;
    assign step_lo   = key_below ? ({1'b0, mid_reg} + sfl_pkg::CNT_W'(1)) : lo_reg;
    assign step_hi   = key_below ? hi_reg : {1'b0, mid_reg};

    assign src_lo    = cmd.step ? step_lo : lo_reg;
    assign src_hi    = cmd.step ? step_hi : hi_reg;
    assign mid_sum   = {1'b0, src_lo} + {1'b0, src_hi};
    assign mid_next  = mid_sum[sfl_pkg::IDX_W:1];
    assign status.open = src_lo < src_hi;

    assign last_idx  = lo_reg - sfl_pkg::CNT_W'(1);

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.init)
        begin
            lo_next = '0;
            hi_next = limit;
        end
        else if (cmd.step)
        begin
            lo_next = step_lo;
            hi_next = step_hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            query_reg <= key;
        end
        if (cmd.first || cmd.step)
        begin
            mid_reg <= mid_next;
        end
    end

    sfl_ram #(
        .WIDTH (sfl_pkg::KEY_W),
        .DEPTH (sfl_pkg::TABLE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (key),
        .re    (cmd.first || cmd.step),
        .raddr (mid_next),
        .rdata (key_rdata)
    );

    sfl_ram #(
        .WIDTH (sfl_pkg::VAL_W),
        .DEPTH (sfl_pkg::TABLE_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (entry_value),
        .re    (cmd.fetch),
        .raddr (last_idx[sfl_pkg::IDX_W-1:0]),
        .rdata (val_rdata)
    );

    assign found       = lo_reg != '0;
    assign found_index = found ? sfl_pkg::LOAD_W'(last_idx) : '0;
    assign step_value  = found ? val_rdata : '0;

endmodule

[sv/step_function_lookup_top.sv]
// Query: accepted at an edge; done pulses in REPORT after SETUP, SEARCH and FINISH,
// with one SEARCH state per bisection step, at most ceil(log2(n + 1)) steps for n entries
// in use: at most 11. One key-store read per step; next request taken the cycle after done.
// Load: written at the accepting edge, no result, next request taken the following cycle.
// Reset: entry_count returns to 1 and the controller idles; the stores are not cleared.
// The receiver cannot stall: every result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
// Step function lookup top level
// Command port, APB register for entry_count, controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module step_function_lookup_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 req_type,
    input  logic [sfl_pkg::LOAD_W-1:0]           load_index,
    input  logic signed [sfl_pkg::KEY_W-1:0]     key,
    input  logic [sfl_pkg::VAL_W-1:0]            entry_value,
    output logic                                 done,
    output logic                                 found,
    output logic [sfl_pkg::LOAD_W-1:0]           found_index,
    output logic [sfl_pkg::VAL_W-1:0]            step_value,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sfl_pkg::APB_AW-1:0]           paddr,
    input  logic [sfl_pkg::APB_DW-1:0]           pwdata,
    output logic [sfl_pkg::APB_DW-1:0]           prdata,
    output logic                                 pready
);

    logic [sfl_pkg::ENTRY_COUNT_W-1:0] entry_count_reg;
    logic [sfl_pkg::ENTRY_COUNT_W-1:0] entry_count_next;
    logic                              reg_sel;
    sfl_pkg::cmd_t                     cmd;
    sfl_pkg::status_t                  status;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_comb
    begin
        entry_count_next = entry_count_reg;
        if (psel && penable && pwrite && (reg_sel == sfl_pkg::REG_ENTRY_COUNT))
        begin
            entry_count_next = pwdata[sfl_pkg::ENTRY_COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= sfl_pkg::ENTRY_COUNT_W'(1);
        end
        else
        begin
            entry_count_reg <= entry_count_next;
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            sfl_pkg::REG_ENTRY_COUNT: prdata = sfl_pkg::APB_DW'(entry_count_reg);
            default:                  prdata = '0;
        endcase
    end

    sfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    sfl_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .entry_count (entry_count_reg),
        .load_index  (load_index),
        .key         (key),
        .entry_value (entry_value),
        .found       (found),
        .found_index (found_index),
        .step_value  (step_value)
    );

endmodule

[tb/sv/step_function_lookup_checker.sv]
// ---------------------------------------------------------------------------
// Step function lookup checker
// Watches the request, result and APB channels, keeps its own copy of the
// key/value tables and entry_count, predicts each query's predecessor
// lookup and compares every result field against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module step_function_lookup_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                req_type,
    input  logic [sfl_pkg::LOAD_W-1:0]          load_index,
    input  logic signed [sfl_pkg::KEY_W-1:0]    key,
    input  logic [sfl_pkg::VAL_W-1:0]           entry_value,
    input  logic                                done,
    input  logic                                found,
    input  logic [sfl_pkg::LOAD_W-1:0]          found_index,
    input  logic [sfl_pkg::VAL_W-1:0]           step_value,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfl_pkg::APB_AW-1:0]          paddr,
    input  logic [sfl_pkg::APB_DW-1:0]          pwdata,
    input  logic [sfl_pkg::APB_DW-1:0]          prdata,
    input  logic                                pready,
    output int                                  mismatch_count,
    output int                                  lookups_pending
);

    typedef struct {
        logic                       hit;
        logic [sfl_pkg::LOAD_W-1:0] index;
        logic [sfl_pkg::VAL_W-1:0]  value;
    } lookup_t;

    logic signed [sfl_pkg::KEY_W-1:0]  key_table [sfl_pkg::TABLE_DEPTH];
    logic [sfl_pkg::VAL_W-1:0]         value_table [sfl_pkg::TABLE_DEPTH];
    logic [sfl_pkg::ENTRY_COUNT_W-1:0] entry_count_q;
    lookup_t                           lookups_due [$];
    int                                errors = 0;

    function automatic lookup_t predecessor_lookup(logic signed [sfl_pkg::KEY_W-1:0] query);
        lookup_t res;
        int      n;
        int      lo;
        int      hi;
        int      mid;
        n  = (entry_count_q > sfl_pkg::TABLE_DEPTH) ? sfl_pkg::TABLE_DEPTH
                                                    : int'(entry_count_q);
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (key_table[mid] < query)
                lo = mid + 1;
            else
                hi = mid;
        end
        res.hit   = 1'b0;
        res.index = '0;
        res.value = '0;
        if (lo != 0)
        begin
            res.hit   = 1'b1;
            res.index = sfl_pkg::LOAD_W'(lo - 1);
            res.value = value_table[lo - 1];
        end
        return res;
    endfunction

    task automatic check_field(string field, logic [sfl_pkg::APB_DW-1:0] want,
                               logic [sfl_pkg::APB_DW-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h actual 0x%0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t due;
        if (!rst_n)
        begin
            entry_count_q = sfl_pkg::ENTRY_COUNT_W'(1);
            lookups_due.delete();
        end
        else
        begin
            if (start && !busy)
            begin
                if (req_type == sfl_pkg::REQ_LOAD)
                begin
                    key_table[load_index]   = key;
                    value_table[load_index] = entry_value;
                end
                else
                    lookups_due.push_back(predecessor_lookup(key));
            end
            if (done)
            begin
                if (lookups_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none actual found=%0b index=%0d",
                             $time, found, found_index);
                end
                else
                begin
                    due = lookups_due.pop_front();
                    check_field("found", sfl_pkg::APB_DW'(due.hit), sfl_pkg::APB_DW'(found));
                    check_field("found_index", sfl_pkg::APB_DW'(due.index),
                                sfl_pkg::APB_DW'(found_index));
                    check_field("step_value", sfl_pkg::APB_DW'(due.value),
                                sfl_pkg::APB_DW'(step_value));
                end
            end
            if (psel && penable && pready && (paddr[2] == sfl_pkg::REG_ENTRY_COUNT))
            begin
                if (pwrite)
                    entry_count_q = pwdata[sfl_pkg::ENTRY_COUNT_W-1:0];
                else
                    check_field("entry_count read", sfl_pkg::APB_DW'(entry_count_q), prdata);
            end
        end
        lookups_pending <= lookups_due.size();
        mismatch_count  <= errors;
    end

endmodule

[tb/sv/tb_top.sv]
// ---------------------------------------------------------------------------
// Step function lookup testbench
// Loads ascending and some scrambled key tables, sweeps entry_count over APB (zero, one, full
// and beyond the table) and issues directed and random queries, with random
// request gaps; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int ITEM_TARGET   = 1550;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 16;

    localparam logic [sfl_pkg::APB_AW-1:0] ADDR_ENTRY_COUNT =
        sfl_pkg::APB_AW'(4 * sfl_pkg::REG_ENTRY_COUNT);
    localparam logic [sfl_pkg::APB_AW-1:0] ADDR_UNMAPPED    =
        sfl_pkg::APB_AW'(4 * (sfl_pkg::REG_ENTRY_COUNT + 1));

    localparam logic signed [sfl_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [sfl_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             start       = 1'b0;
    logic                             busy;
    logic                             req_type    = sfl_pkg::REQ_LOAD;
    logic [sfl_pkg::LOAD_W-1:0]       load_index  = '0;
    logic signed [sfl_pkg::KEY_W-1:0] key         = '0;
    logic [sfl_pkg::VAL_W-1:0]        entry_value = '0;
    logic                             done;
    logic                             found;
    logic [sfl_pkg::LOAD_W-1:0]       found_index;
    logic [sfl_pkg::VAL_W-1:0]        step_value;
    logic                             psel        = 1'b0;
    logic                             penable     = 1'b0;
    logic                             pwrite      = 1'b0;
    logic [sfl_pkg::APB_AW-1:0]       paddr       = '0;
    logic [sfl_pkg::APB_DW-1:0]       pwdata      = '0;
    logic [sfl_pkg::APB_DW-1:0]       prdata;
    logic                             pready;

    int                               mismatch_count;
    int                               lookups_pending;
    int                               items_sent  = 0;
    bit                               steady      = 1'b0;
    longint                           cycle_count = 0;
    logic signed [sfl_pkg::KEY_W-1:0] key_shadow [sfl_pkg::TABLE_DEPTH];

    step_function_lookup_top DUT (.*);

    step_function_lookup_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_request(logic kind, logic [sfl_pkg::LOAD_W-1:0] idx,
                                logic signed [sfl_pkg::KEY_W-1:0] k,
                                logic [sfl_pkg::VAL_W-1:0] v);
        int gap;
        start       <= 1'b1;
        req_type    <= kind;
        load_index  <= idx;
        key         <= k;
        entry_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if ($urandom_range(0, 31) == 0)
            steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_load(int idx, logic signed [sfl_pkg::KEY_W-1:0] k,
                             logic [sfl_pkg::VAL_W-1:0] v);
        key_shadow[idx] = k;
        send_request(sfl_pkg::REQ_LOAD, sfl_pkg::LOAD_W'(idx), k, v);
    endtask

    task automatic send_query(logic signed [sfl_pkg::KEY_W-1:0] k);
        send_request(sfl_pkg::REQ_QUERY, sfl_pkg::LOAD_W'($urandom), k, $urandom);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (lookups_pending != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(logic write, logic [sfl_pkg::APB_AW-1:0] addr,
                              logic [sfl_pkg::APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_entry_count(int count);
        logic [sfl_pkg::APB_DW-1:0] word;
        word = $urandom;
        word[sfl_pkg::ENTRY_COUNT_W-1:0] = sfl_pkg::ENTRY_COUNT_W'(count);
        wait_idle();
        if ($urandom_range(0, 3) == 0)
            apb_access(1'b1, ADDR_UNMAPPED, $urandom);
        apb_access(1'b1, ADDR_ENTRY_COUNT, word);
        apb_access(1'b0, ADDR_ENTRY_COUNT, '0);
    endtask

    task automatic load_table(int n, int span, bit scrambled);
        longint k;
        k = ($urandom_range(0, 3) == 0) ? -64'sd2147483648 : longint'(int'($urandom));
        for (int i = 0; i < n; i++)
        begin
            if (scrambled)
                send_load(i, $urandom, $urandom);
            else
            begin
                send_load(i, sfl_pkg::KEY_W'(k), $urandom);
                if ($urandom_range(0, 5) != 0)
                    k += $urandom_range(1, span);
                if (k > 64'sd2147483647)
                    k = 64'sd2147483647;
            end
        end
    endtask

    function automatic logic signed [sfl_pkg::KEY_W-1:0] pick_key(int eff);
        int i;
        if (eff == 0)
            return $urandom;
        i = $urandom_range(0, eff - 1);
        case ($urandom_range(0, 9)) inside
            [0:3]:   return key_shadow[i];
            4:       return key_shadow[i] + 1;
            5:       return key_shadow[i] - 1;
            6:       return $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_queries(int eff, int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_load($urandom_range(0, sfl_pkg::TABLE_DEPTH - 1), $urandom, $urandom);
            else
                send_query(pick_key(eff));
        end
    endtask

    initial
    begin
        int count;
        int eff;
        int span;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single entry at reset count, ties and extremes
        apb_access(1'b0, ADDR_ENTRY_COUNT, '0);
        send_load(0, 32'shFFFB_0000, 32'hFFFF_FFFF);
        send_query(32'shFFFB_0000);
        send_query(KEY_MAX);
        send_query(KEY_MIN);

        // run of equal keys and a key at the top of the range
        set_entry_count(4);
        send_load(1, 32'sh0, 32'h0);
        send_load(2, 32'sh0, 32'h1234_5678);
        send_load(3, KEY_MAX, 32'h0001_0000);
        send_query(32'sh0);
        send_query(32'sh1);
        send_query(KEY_MAX);
        send_query(KEY_MIN);
        send_query(32'shFFFB_0001);

        // empty table, then a write to an unmapped register
        set_entry_count(0);
        send_query(KEY_MAX);
        wait_idle();
        apb_access(1'b1, ADDR_UNMAPPED, 32'h0000_07FF);
        send_query(KEY_MAX);

        // unsorted table
        set_entry_count(3);
        send_load(1, KEY_MAX, 32'hA5A5_5A5A);
        send_query(32'sh5);

        // full table, counts at and beyond the depth
        load_table(sfl_pkg::TABLE_DEPTH, 32'h003F_FFFF, 1'b0);
        set_entry_count(sfl_pkg::TABLE_DEPTH);
        run_queries(sfl_pkg::TABLE_DEPTH, 12);
        set_entry_count(2047);
        run_queries(sfl_pkg::TABLE_DEPTH, 12);
        set_entry_count(sfl_pkg::TABLE_DEPTH + 1);
        run_queries(sfl_pkg::TABLE_DEPTH, 12);

        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 15))
                0:       count = 0;
                1:       count = 1;
                2:       count = $urandom_range(sfl_pkg::TABLE_DEPTH + 1, 2047);
                3:       count = sfl_pkg::TABLE_DEPTH;
                default: count = $urandom_range(2, 48);
            endcase
            eff = (count > sfl_pkg::TABLE_DEPTH) ? sfl_pkg::TABLE_DEPTH : count;
            set_entry_count(count);
            if (eff > 0 && eff <= 48)
            begin
                case ($urandom_range(0, 2))
                    0:       span = 2;
                    1:       span = 32'h0000_FFFF;
                    default: span = 32'h003F_FFFF;
                endcase
                load_table(eff, span, $urandom_range(0, 7) == 0);
            end
            run_queries(eff, $urandom_range(6, 20));
        end

        wait_idle();
        if (mismatch_count == 0 && lookups_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
